FILE: sv/prime_sieve_engine_defines.svh
// ----------------------------------------------------------------------------
// Prime sieve engine assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_ENGINE_DEFINES_SVH
`define PRIME_SIEVE_ENGINE_DEFINES_SVH

// Same-cycle implication
`define PSIEVE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PSIEVE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/psieve_pkg.sv
// ----------------------------------------------------------------------------
// Prime sieve engine package
// Item types, action codes and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package psieve_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 13;
    localparam int VALUE_W  = 17;
    localparam int TOTAL_W  = 14;
    // Values up to 2^17 - 1 plus one step of the marking stride
    localparam int SPAN_W   = VALUE_W + 1;
    // Sieve root: i*i stays at most 2^17 - 1, so i never passes 363
    localparam int ROOT_W   = 9;
    localparam int UPC_W    = 5;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [UPC_W-1:0]    upc_t;

    localparam action_t ACT_BUILD = 2'd0;
    localparam action_t ACT_READ  = 2'd1;
    localparam action_t ACT_TEST  = 2'd2;

    typedef struct packed {
        action_t              action;
        logic [INDEX_W-1:0]   prime_index;
        logic [VALUE_W-1:0]   test_value;
    } psieve_in_t;

    typedef struct packed {
        logic                 status;
        logic [VALUE_W-1:0]   prime_value;
        logic [TOTAL_W-1:0]   prime_total;
        logic                 is_prime;
    } psieve_out_t;

    // Datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CLR_INIT,
        OP_CLR,
        OP_SV_INIT,
        OP_RD_I,
        OP_MARK_INIT,
        OP_MARK,
        OP_SV_NEXT,
        OP_LS_INIT,
        OP_RD_P,
        OP_LS_EVAL,
        OP_EMIT_BUILD,
        OP_RD_LIST,
        OP_EMIT_READ,
        OP_RD_VAL,
        OP_EMIT_TEST,
        OP_EMIT_BAD
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_P_LT_LIM,
        C_SQ_GT_LIM,
        C_COMPOSITE,
        C_MARK_MORE,
        C_P_GT_LIM
    } cond_t;

    // Stall sources of a step
    typedef enum logic [1:0] {
        H_NONE,
        H_INPUT,
        H_OUTPUT
    } hold_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        hold_t hold;
        upc_t  target;
    } ctrl_word_t;

    // Condition flags from the datapath
    typedef struct packed {
        logic    in_valid;
        logic    out_busy;
        action_t action;
        logic    p_lt_lim;
        logic    sq_gt_lim;
        logic    composite;
        logic    mark_more;
        logic    p_gt_lim;
    } psieve_flags_t;

    // Current step as seen by the datapath
    typedef struct packed {
        ctrl_word_t cw;
        logic       go;
    } psieve_step_t;

    // Program addresses
    localparam upc_t S_IDLE       = 5'd0;
    localparam upc_t S_CLR_INIT   = 5'd1;
    localparam upc_t S_CLR        = 5'd2;
    localparam upc_t S_SV_INIT    = 5'd3;
    localparam upc_t S_SV_TEST    = 5'd4;
    localparam upc_t S_SV_CHECK   = 5'd5;
    localparam upc_t S_SV_MARK    = 5'd6;
    localparam upc_t S_SV_NEXT    = 5'd7;
    localparam upc_t S_LS_INIT    = 5'd8;
    localparam upc_t S_LS_READ    = 5'd9;
    localparam upc_t S_LS_EVAL    = 5'd10;
    localparam upc_t S_BUILD_DONE = 5'd11;
    localparam upc_t S_RD_REQ     = 5'd12;
    localparam upc_t S_RD_DONE    = 5'd13;
    localparam upc_t S_TS_REQ     = 5'd14;
    localparam upc_t S_TS_DONE    = 5'd15;
    localparam upc_t S_BAD        = 5'd16;

    // Microcode program
    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t w;
        w = '{OP_NOP, C_ALWAYS, H_NONE, S_IDLE};
        case (addr)
            S_IDLE:       w = '{OP_ACCEPT,     C_DISPATCH,  H_INPUT,  S_IDLE};
            S_CLR_INIT:   w = '{OP_CLR_INIT,   C_NEVER,     H_NONE,   S_IDLE};
            S_CLR:        w = '{OP_CLR,        C_P_LT_LIM,  H_NONE,   S_CLR};
            S_SV_INIT:    w = '{OP_SV_INIT,    C_NEVER,     H_NONE,   S_IDLE};
            S_SV_TEST:    w = '{OP_RD_I,       C_SQ_GT_LIM, H_NONE,   S_LS_INIT};
            S_SV_CHECK:   w = '{OP_MARK_INIT,  C_COMPOSITE, H_NONE,   S_SV_NEXT};
            S_SV_MARK:    w = '{OP_MARK,       C_MARK_MORE, H_NONE,   S_SV_MARK};
            S_SV_NEXT:    w = '{OP_SV_NEXT,    C_ALWAYS,    H_NONE,   S_SV_TEST};
            S_LS_INIT:    w = '{OP_LS_INIT,    C_NEVER,     H_NONE,   S_IDLE};
            S_LS_READ:    w = '{OP_RD_P,       C_P_GT_LIM,  H_NONE,   S_BUILD_DONE};
            S_LS_EVAL:    w = '{OP_LS_EVAL,    C_ALWAYS,    H_NONE,   S_LS_READ};
            S_BUILD_DONE: w = '{OP_EMIT_BUILD, C_ALWAYS,    H_OUTPUT, S_IDLE};
            S_RD_REQ:     w = '{OP_RD_LIST,    C_NEVER,     H_NONE,   S_IDLE};
            S_RD_DONE:    w = '{OP_EMIT_READ,  C_ALWAYS,    H_OUTPUT, S_IDLE};
            S_TS_REQ:     w = '{OP_RD_VAL,     C_NEVER,     H_NONE,   S_IDLE};
            S_TS_DONE:    w = '{OP_EMIT_TEST,  C_ALWAYS,    H_OUTPUT, S_IDLE};
            S_BAD:        w = '{OP_EMIT_BAD,   C_ALWAYS,    H_OUTPUT, S_IDLE};
            default:      w = '{OP_NOP,        C_ALWAYS,    H_NONE,   S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each action
    function automatic upc_t dispatch_target(input action_t action);
        upc_t t;
        case (action)
            ACT_BUILD: t = S_CLR_INIT;
            ACT_READ:  t = S_RD_REQ;
            ACT_TEST:  t = S_TS_REQ;
            default:   t = S_BAD;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/psieve_seq.sv
// ----------------------------------------------------------------------------
// Prime sieve microcode sequencer
// Step counter over the program table, with stalls and conditional jumps.
// ----------------------------------------------------------------------------
module psieve_seq
    import psieve_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  psieve_flags_t flags,
    output psieve_step_t  step
);

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t cw;
    logic       stall;
    logic       take_jump;

    // Fetch the control word of the current step
    assign cw = ucode_rom(upc_reg);

    // Hold the step while its channel is not ready
    always_comb begin
        case (cw.hold)
            H_INPUT:  stall = !flags.in_valid;
            H_OUTPUT: stall = flags.out_busy;
            default:  stall = 1'b0;
        endcase
    end

    // Evaluate the jump condition
    always_comb begin
        case (cw.cond)
            C_ALWAYS:    take_jump = 1'b1;
            C_P_LT_LIM:  take_jump = flags.p_lt_lim;
            C_SQ_GT_LIM: take_jump = flags.sq_gt_lim;
            C_COMPOSITE: take_jump = flags.composite;
            C_MARK_MORE: take_jump = flags.mark_more;
            C_P_GT_LIM:  take_jump = flags.p_gt_lim;
            default:     take_jump = 1'b0;
        endcase
    end

    // Advance, jump or dispatch
    always_comb begin
        if (stall) begin
            upc_next = upc_reg;
        end else if (cw.cond == C_DISPATCH) begin
            upc_next = dispatch_target(flags.action);
        end else if (take_jump) begin
            upc_next = cw.target;
        end else begin
            upc_next = upc_reg + UPC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign step.cw = cw;
    assign step.go = !stall;

endmodule

FILE: sv/prime_sieve_engine.sv
// ----------------------------------------------------------------------------
// Prime sieve engine
// Builds a composite bit map up to a configured limit, lists the primes and
// answers k-th prime reads and primality tests from the last build.
// ----------------------------------------------------------------------------
//  channel | direction | ports                        | carries
//  --------+-----------+------------------------------+-------------------------
//  cfg     | in        | cfg_valid cfg_ready cfg_data | sieve_limit register
//  s_      | in        | s_valid s_ready s_data       | action, index, test value
//  m_      | out       | m_valid m_ready m_data       | status, prime, total, flag
//
//  A build clears the map up to the limit, checks each sieve root, marks the
//  multiples of each prime root and lists the primes, all through the single
//  port of the bit map memory. A read or a test issues one memory read, then
//  emits its result. Items are handled one at a time; the result register
//  lets the next item in while a result waits on m_ready.
//  Reset is synchronous, active low; items are taken from the first cycle
//  after it is released.
// ----------------------------------------------------------------------------
module prime_sieve_engine
    import psieve_pkg::*;
#(
    parameter int unsigned LIMIT_MAX   = 65536,
    parameter int unsigned PRIME_SLOTS = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [VALUE_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  psieve_in_t         s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output psieve_out_t        m_data
);

    localparam int AW    = $clog2(LIMIT_MAX + 1);
    localparam int LW    = $clog2(PRIME_SLOTS);
    localparam int CW    = $clog2(PRIME_SLOTS + 1);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    // Memories
    logic               map_mem  [0:LIMIT_MAX];
    logic [VALUE_W-1:0] list_mem [0:PRIME_SLOTS-1];

    logic               map_we;
    logic               map_re;
    logic [AW-1:0]      map_addr;
    logic               map_wd;
    logic               map_rd_reg;
    logic               list_we;
    logic               list_re;
    logic [LW-1:0]      list_waddr;
    logic [VALUE_W-1:0] list_wd;
    logic [VALUE_W-1:0] list_rd_reg;

    // Registers
    logic [VALUE_W-1:0] sieve_limit_reg;
    action_t            action_reg, action_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] lim_reg, lim_next;
    logic [SPAN_W-1:0]  p_reg, p_next;
    logic [ROOT_W-1:0]  i_reg, i_next;
    logic [SPAN_W-1:0]  sq_reg, sq_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [VALUE_W-1:0] built_limit_reg, built_limit_next;
    logic               built_valid_reg, built_valid_next;
    logic               m_valid_reg, m_valid_next;
    psieve_out_t        m_data_reg, m_data_next;

    psieve_flags_t      flags;
    psieve_step_t       step;
    logic [SPAN_W-1:0]  lim_ext;
    logic [SPAN_W-1:0]  p_step;
    logic [VALUE_W-1:0] lim_sat;
    logic               read_ok;
    logic               test_ok;

    // Sequencer
    psieve_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .step    (step)
    );

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sieve_limit_reg <= '0;
        end else if (cfg_valid) begin
            sieve_limit_reg <= cfg_data;
        end
    end

    // Saturate the limit to the map size
    assign lim_sat = (32'(sieve_limit_reg) > 32'(LIMIT_MAX)) ? VALUE_W'(LIMIT_MAX)
                                                             : sieve_limit_reg;

    assign lim_ext = SPAN_W'(lim_reg);
    assign p_step  = p_reg + SPAN_W'(i_reg);
    assign read_ok = built_valid_reg && (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign test_ok = built_valid_reg && (val_reg <= built_limit_reg);

    // Flags for the sequencer
    assign flags.in_valid  = s_valid;
    assign flags.out_busy  = m_valid_reg && !m_ready;
    assign flags.action    = s_data.action;
    assign flags.p_lt_lim  = p_reg < lim_ext;
    assign flags.sq_gt_lim = sq_reg > lim_ext;
    assign flags.composite = map_rd_reg;
    assign flags.mark_more = p_step <= lim_ext;
    assign flags.p_gt_lim  = p_reg > lim_ext;

    assign s_ready = (step.cw.op == OP_ACCEPT);

    // Datapath driven by the control word
    always_comb begin
        action_next      = action_reg;
        idx_next         = idx_reg;
        val_next         = val_reg;
        lim_next         = lim_reg;
        p_next           = p_reg;
        i_next           = i_reg;
        sq_next          = sq_reg;
        count_next       = count_reg;
        built_limit_next = built_limit_reg;
        built_valid_next = built_valid_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        map_we           = 1'b0;
        map_re           = 1'b0;
        map_addr         = '0;
        map_wd           = 1'b0;
        list_we          = 1'b0;
        list_re          = 1'b0;
        list_waddr       = LW'(count_reg);
        list_wd          = VALUE_W'(p_reg);

        if (step.go) begin
            case (step.cw.op)
                OP_ACCEPT: begin
                    action_next = s_data.action;
                    idx_next    = s_data.prime_index;
                    val_next    = s_data.test_value;
                end
                OP_CLR_INIT: begin
                    lim_next = lim_sat;
                    p_next   = '0;
                end
                // Clear the map, marking 0 and 1 composite
                OP_CLR: begin
                    map_we   = 1'b1;
                    map_addr = AW'(p_reg);
                    map_wd   = (p_reg < SPAN_W'(2));
                    p_next   = p_reg + SPAN_W'(1);
                end
                OP_SV_INIT: begin
                    i_next  = ROOT_W'(2);
                    sq_next = SPAN_W'(4);
                end
                OP_RD_I: begin
                    map_re   = 1'b1;
                    map_addr = AW'(i_reg);
                end
                OP_MARK_INIT: begin
                    p_next = sq_reg;
                end
                // Mark one multiple, stride by the root
                OP_MARK: begin
                    map_we   = 1'b1;
                    map_addr = AW'(p_reg);
                    map_wd   = 1'b1;
                    p_next   = p_step;
                end
                // Next root; (i+1)^2 = i^2 + 2i + 1
                OP_SV_NEXT: begin
                    i_next  = i_reg + ROOT_W'(1);
                    sq_next = sq_reg + SPAN_W'({i_reg, 1'b1});
                end
                OP_LS_INIT: begin
                    p_next     = SPAN_W'(2);
                    count_next = '0;
                end
                OP_RD_P: begin
                    map_re   = 1'b1;
                    map_addr = AW'(p_reg);
                end
                // Append a prime while slots remain
                OP_LS_EVAL: begin
                    if (!map_rd_reg && (count_reg < CW'(PRIME_SLOTS))) begin
                        list_we    = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    p_next = p_reg + SPAN_W'(1);
                end
                OP_EMIT_BUILD: begin
                    built_limit_next        = lim_reg;
                    built_valid_next        = 1'b1;
                    m_data_next.status      = 1'b0;
                    m_data_next.prime_value = '0;
                    m_data_next.prime_total = TOTAL_W'(count_reg);
                    m_data_next.is_prime    = 1'b0;
                    m_valid_next            = 1'b1;
                end
                OP_RD_LIST: begin
                    list_re = 1'b1;
                end
                OP_EMIT_READ: begin
                    m_data_next.status      = !read_ok;
                    m_data_next.prime_value = read_ok ? list_rd_reg : '0;
                    m_data_next.prime_total = TOTAL_W'(count_reg);
                    m_data_next.is_prime    = 1'b0;
                    m_valid_next            = 1'b1;
                end
                OP_RD_VAL: begin
                    map_re   = 1'b1;
                    map_addr = test_ok ? AW'(val_reg) : '0;
                end
                OP_EMIT_TEST: begin
                    m_data_next.status      = !test_ok;
                    m_data_next.prime_value = '0;
                    m_data_next.prime_total = TOTAL_W'(count_reg);
                    m_data_next.is_prime    = test_ok && !map_rd_reg;
                    m_valid_next            = 1'b1;
                end
                OP_EMIT_BAD: begin
                    m_data_next.status      = 1'b1;
                    m_data_next.prime_value = '0;
                    m_data_next.prime_total = TOTAL_W'(count_reg);
                    m_data_next.is_prime    = 1'b0;
                    m_valid_next            = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Bit map: one port, registered read
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_addr] <= map_wd;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_addr];
        end
    end

    // Prime list: write at the fill position, read at the requested index
    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wd;
        end
        if (list_re) begin
            list_rd_reg <= list_mem[LW'(idx_reg)];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            built_limit_reg <= '0;
            built_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            count_reg       <= count_next;
            built_limit_reg <= built_limit_next;
            built_valid_reg <= built_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        lim_reg    <= lim_next;
        p_reg      <= p_next;
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/psieve_chk.sv
// ----------------------------------------------------------------------------
// Prime sieve engine port checker
// Watches the ports for one-item-at-a-time ordering and result hold.
// ----------------------------------------------------------------------------
`include "prime_sieve_engine_defines.svh"

module psieve_chk
    import psieve_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input psieve_out_t m_data
);

    logic pend_reg;
    logic prev_valid_reg;
    logic prev_take_reg;
    logic in_take;
    logic new_res;

    assign in_take = s_valid && s_ready;
    // A fresh result shows up when valid rises or right after a take
    assign new_res = m_valid && (!prev_valid_reg || prev_take_reg);

    // Track an accepted item whose result has not shown up yet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_take_reg  <= 1'b0;
        end else begin
            pend_reg       <= in_take || (pend_reg && !new_res);
            prev_valid_reg <= m_valid;
            prev_take_reg  <= m_valid && m_ready;
        end
    end

    `PSIEVE_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `PSIEVE_ASSERT_NXT(a_ready_drop, in_take, !s_ready, "ready stayed high after an item")
    `PSIEVE_ASSERT_IMP(a_res_owed, new_res, pend_reg, "result without an accepted item")
    `PSIEVE_ASSERT_IMP(a_one_item, in_take, !pend_reg || new_res, "item taken while one is in work")
    `PSIEVE_ASSERT_IMP(a_err_clean, m_valid && m_data.status, !m_data.is_prime && (m_data.prime_value == '0), "error result carries data")

endmodule

bind prime_sieve_engine psieve_chk u_psieve_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Prime sieve engine testbench
// Drives build, read, test and unknown items into the engine, with random
// gaps on the input side and random stalls on the result side. A local sieve
// tracks the limit register and the last build and works out each result. A
// directed table covers the error paths, tiny and saturated limits, and the
// ends of the index and value ranges. Random phases follow, each with a fresh
// limit, a build, and a mix of reads, tests, rebuilds and bad items.
// ----------------------------------------------------------------------------
module testbench;
    import psieve_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_MAX       = 65536;
    localparam int unsigned PRIME_SLOTS     = 8192;
    localparam int          CLK_PERIOD      = 10;
    localparam int          WATCHDOG_CYCLES = 1500000;
    localparam int          MAX_REPORTS     = 10;
    localparam action_t     ACT_UNKNOWN     = 2'd3;
    localparam int          KEEP_LIMIT      = -1;
    localparam bit          TYPED           = 1'b1;
    localparam bit          FREE            = 1'b0;

    typedef struct packed {
        logic        typed;
        psieve_out_t result;
    } result_hint_t;

    typedef struct {
        int          limit;
        psieve_in_t  item;
        bit          typed;
        psieve_out_t result;
    } plan_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [VALUE_W-1:0] cfg_data = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    psieve_in_t  s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    psieve_out_t m_data;

    // Local copy of the engine state
    bit                 comp_map [0:LIMIT_MAX];
    logic [VALUE_W-1:0] primes   [0:PRIME_SLOTS-1];
    int unsigned        prime_cnt = 0;
    int unsigned        built_lim = 0;
    bit                 built_ok  = 1'b0;
    int unsigned        limit_reg = 0;

    psieve_out_t  expected_q [$];
    result_hint_t hint_q     [$];
    int           items_sent   = 0;
    int           results_seen = 0;
    int           errors       = 0;
    int           quiet        = 0;
    bit           steady       = 1'b0;
    plan_row_t    plan [0:24];

    prime_sieve_engine #(
        .LIMIT_MAX  (LIMIT_MAX),
        .PRIME_SLOTS(PRIME_SLOTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one item to the local sieve and return the result it causes
    function automatic psieve_out_t sieve_predict(input psieve_in_t it);
        psieve_out_t r;
        int unsigned lim, i, j;
        r = '0;
        r.status = 1'b1;
        case (it.action)
            ACT_BUILD: begin
                lim = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
                for (i = 0; i <= lim; i++) comp_map[i] = 1'b0;
                comp_map[0] = 1'b1;
                comp_map[1] = 1'b1;
                for (i = 2; i * i <= lim; i++) begin
                    if (!comp_map[i]) begin
                        for (j = i * i; j <= lim; j += i) comp_map[j] = 1'b1;
                    end
                end
                prime_cnt = 0;
                for (i = 2; i <= lim; i++) begin
                    if (!comp_map[i] && prime_cnt < PRIME_SLOTS) begin
                        primes[prime_cnt] = i[VALUE_W-1:0];
                        prime_cnt++;
                    end
                end
                built_lim = lim;
                built_ok  = 1'b1;
                r.status  = 1'b0;
            end
            ACT_READ: begin
                if (built_ok && it.prime_index < prime_cnt) begin
                    r.prime_value = primes[it.prime_index];
                    r.status      = 1'b0;
                end
            end
            ACT_TEST: begin
                if (built_ok && it.test_value <= built_lim) begin
                    r.is_prime = !comp_map[it.test_value];
                    r.status   = 1'b0;
                end
            end
            default: ;
        endcase
        r.prime_total = prime_cnt[TOTAL_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t mk_row(input int limit, input action_t act, input int idx,
                                         input int val, input bit typed, input bit st,
                                         input int pv, input int tot, input bit isp);
        plan_row_t r;
        r.limit              = limit;
        r.item.action        = act;
        r.item.prime_index   = idx[INDEX_W-1:0];
        r.item.test_value    = val[VALUE_W-1:0];
        r.typed              = typed;
        r.result.status      = st;
        r.result.prime_value = pv[VALUE_W-1:0];
        r.result.prime_total = tot[TOTAL_W-1:0];
        r.result.is_prime    = isp;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input psieve_out_t want,
                                 input psieve_out_t got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch %s: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                     what, want.status, want.prime_value, want.prime_total, want.is_prime,
                     got.status, got.prime_value, got.prime_total, got.is_prime);
        end
    endtask

    // Hold valid with a stable payload until the engine takes the item
    task automatic send_item(input psieve_in_t it, input bit typed, input psieve_out_t result);
        int unsigned  gap;
        result_hint_t hint;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        hint.typed  = typed;
        hint.result = result;
        hint_q = {hint_q, hint};
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[VALUE_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Track register writes
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) limit_reg = 32'(cfg_data);
    end

    // Predict on every accepted item; typed table rows override the prediction
    always @(posedge aclk) begin : item_monitor
        psieve_out_t  pred;
        result_hint_t hint;
        if (aresetn && s_valid && s_ready) begin
            pred = sieve_predict(s_data);
            hint = hint_q.pop_front();
            if (hint.typed) pred = hint.result;
            expected_q = {expected_q, pred};
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        psieve_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result", '0, m_data);
            end else begin
                want = expected_q.pop_front();
                if (want.status !== m_data.status || want.prime_value !== m_data.prime_value ||
                    want.prime_total !== m_data.prime_total ||
                    want.is_prime !== m_data.is_prime) begin
                    note_mismatch("field", want, m_data);
                end
            end
        end
    end

    // Result side: random stall before taking each result
    initial begin : result_sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_CYCLES) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        psieve_in_t  it;
        int unsigned lim, pick;
        int          ph, n;

        // Error paths before any build, tiny limits, saturated limit, range ends
        plan[0]  = mk_row(KEEP_LIMIT, ACT_READ,    0,    0,      TYPED, 1, 0,     0,    0);
        plan[1]  = mk_row(KEEP_LIMIT, ACT_TEST,    0,    0,      TYPED, 1, 0,     0,    0);
        plan[2]  = mk_row(KEEP_LIMIT, ACT_UNKNOWN, 0,    0,      TYPED, 1, 0,     0,    0);
        plan[3]  = mk_row(KEEP_LIMIT, ACT_BUILD,   0,    0,      TYPED, 0, 0,     0,    0);
        plan[4]  = mk_row(KEEP_LIMIT, ACT_TEST,    0,    0,      TYPED, 0, 0,     0,    0);
        plan[5]  = mk_row(KEEP_LIMIT, ACT_TEST,    0,    1,      TYPED, 1, 0,     0,    0);
        plan[6]  = mk_row(KEEP_LIMIT, ACT_READ,    0,    0,      TYPED, 1, 0,     0,    0);
        plan[7]  = mk_row(1,          ACT_BUILD,   0,    0,      TYPED, 0, 0,     0,    0);
        plan[8]  = mk_row(KEEP_LIMIT, ACT_TEST,    0,    1,      TYPED, 0, 0,     0,    0);
        plan[9]  = mk_row(KEEP_LIMIT, ACT_TEST,    0,    2,      TYPED, 1, 0,     0,    0);
        plan[10] = mk_row(131071,     ACT_BUILD,   0,    0,      TYPED, 0, 0,     6542, 0);
        plan[11] = mk_row(KEEP_LIMIT, ACT_READ,    0,    0,      TYPED, 0, 2,     6542, 0);
        plan[12] = mk_row(KEEP_LIMIT, ACT_READ,    6541, 0,      TYPED, 0, 65521, 6542, 0);
        plan[13] = mk_row(KEEP_LIMIT, ACT_READ,    6542, 0,      TYPED, 1, 0,     6542, 0);
        plan[14] = mk_row(KEEP_LIMIT, ACT_READ,    8191, 0,      TYPED, 1, 0,     6542, 0);
        plan[15] = mk_row(KEEP_LIMIT, ACT_TEST,    0,    65536,  TYPED, 0, 0,     6542, 0);
        plan[16] = mk_row(KEEP_LIMIT, ACT_TEST,    0,    65521,  TYPED, 0, 0,     6542, 1);
        plan[17] = mk_row(KEEP_LIMIT, ACT_TEST,    0,    131071, TYPED, 1, 0,     6542, 0);
        plan[18] = mk_row(KEEP_LIMIT, ACT_UNKNOWN, 8191, 131071, TYPED, 1, 0,     6542, 0);
        plan[19] = mk_row(KEEP_LIMIT, ACT_TEST,    0,    97,     FREE,  0, 0,     0,    0);
        plan[20] = mk_row(KEEP_LIMIT, ACT_READ,    4095, 0,      FREE,  0, 0,     0,    0);
        plan[21] = mk_row(KEEP_LIMIT, ACT_TEST,    5461, 7,      FREE,  0, 0,     0,    0);
        plan[22] = mk_row(2,          ACT_BUILD,   0,    0,      TYPED, 0, 0,     1,    0);
        plan[23] = mk_row(KEEP_LIMIT, ACT_READ,    0,    0,      TYPED, 0, 2,     1,    0);
        plan[24] = mk_row(KEEP_LIMIT, ACT_TEST,    0,    2,      TYPED, 0, 0,     1,    1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (plan[row]) begin
            if (plan[row].limit != KEEP_LIMIT) begin
                hold_until_drained();
                write_limit(plan[row].limit);
            end
            send_item(plan[row].item, plan[row].typed, plan[row].result);
        end

        // Random phases: new limit, build, then mostly well-formed reads and tests
        for (ph = 0; ph < 8; ph++) begin
            hold_until_drained();
            steady = (ph % 3 == 2);
            lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000)
                                               : $urandom_range(0, 400);
            write_limit(lim);
            it = '0;
            it.action = ACT_BUILD;
            send_item(it, FREE, '0);
            hold_until_drained();
            for (n = 0; n < 12; n++) begin
                pick = $urandom_range(0, 19);
                it.prime_index = INDEX_W'($urandom_range(0, PRIME_SLOTS - 1));
                it.test_value  = VALUE_W'($urandom_range(0, 131071));
                if (pick < 8) begin
                    it.action = ACT_READ;
                    it.prime_index = (prime_cnt != 0) ?
                                     INDEX_W'($urandom_range(0, prime_cnt - 1)) : '0;
                end else if (pick < 16) begin
                    it.action = ACT_TEST;
                    it.test_value = VALUE_W'($urandom_range(0, built_lim + 2));
                end else if (pick == 16) begin
                    it.action = ACT_BUILD;
                end else if (pick == 17) begin
                    it.action = ACT_UNKNOWN;
                end else if (pick == 18) begin
                    it.action = ACT_READ;
                end else begin
                    it.action = ACT_TEST;
                end
                send_item(it, FREE, '0);
            end
        end

        // Drain and report
        hold_until_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
